FILE: rtl/isa_pkg.sv
// ============================================================================
// isa_pkg: shared types and constants of the scatter-add engine
// Payload structs, operation and status codes, controller/datapath links.
// ============================================================================
`timescale 1ns / 1ps

package isa_pkg;

    localparam int DATA_W    = 32;
    localparam int OFF_W     = 20;   // item address / flat source offset
    localparam int ICNT_W    = 9;    // index_count
    localparam int DIM_W     = 13;   // dim_size, inner_size
    localparam int SRC_W     = 20;   // source_count
    localparam int SPAN_W    = 22;   // index_count * inner_size
    localparam int MUL1_W    = 33;   // group * dim_size
    localparam int SUM_W     = 34;   // group * dim_size + dest
    localparam int PROD_W    = 47;   // (...) * inner_size
    localparam int TGT_W     = 48;   // target offset
    localparam int REG_IDX_W = 3;
    localparam int DIV_CNT_W = 5;    // counts OFF_W quotient bits

    typedef enum logic [1:0] {
        FUNC_LOAD     = 2'd0,
        FUNC_LOAD_IDX = 2'd1,
        FUNC_SCATTER  = 2'd2,
        FUNC_READ     = 2'd3
    } isa_func_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_DROPPED = 2'd1,
        ST_IGNORED = 2'd2,
        ST_BEYOND  = 2'd3
    } isa_status_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_INDEX_COUNT  = 3'd0,
        REG_DIM_SIZE     = 3'd1,
        REG_INNER_SIZE   = 3'd2,
        REG_SOURCE_COUNT = 3'd3,
        REG_ELEM_TYPE    = 3'd4
    } isa_reg_t;

    typedef struct packed {
        isa_func_t                 func;
        logic [OFF_W-1:0]          addr;
        logic signed [DATA_W-1:0]  data;
    } isa_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  read_data;
        isa_status_t               status;
    } isa_out_t;

    typedef struct packed {
        logic [REG_IDX_W-1:0]      index;
        logic [DATA_W-1:0]         value;
    } isa_cfg_t;

    // controller -> datapath
    typedef struct packed {
        logic        latch;          // capture input item
        logic        tbl_we;
        logic        tbl_re;
        logic        tbl_wsrc_sum;   // write accumulated value, else loaded value
        logic        tbl_asel_tgt;   // table address from target, else item address
        logic        idx_we;
        logic        idx_re;
        logic        div_start;
        logic        div_sel_inner;  // second pass: remainder / inner_size
        logic        take_q1;
        logic        take_q2;
        logic        calc_dest;
        logic        calc_sum;
        logic        calc_prod;
        logic        rd_capture;
        logic        st_we;
        isa_status_t st_code;
        logic        out_load;
    } isa_cmd_t;

    // datapath -> controller
    typedef struct packed {
        isa_func_t func;
        logic      item_in_tbl;
        logic      item_in_idx;
        logic      scat_skip;
        logic      div_done;
        logic      pos_beyond;
        logic      dest_bad;
        logic      tgt_beyond;
        logic      out_free;
    } isa_sts_t;

    // int8 mode keeps the low byte, sign-extended
    function automatic logic [DATA_W-1:0] narrow(input logic [DATA_W-1:0] v,
                                                 input logic int8);
        return int8 ? {{(DATA_W-8){v[7]}}, v[7:0]} : v;
    endfunction

endpackage

FILE: rtl/isa_chan_if.sv
// ============================================================================
// isa_chan_if: valid/ready channel
// One transfer per clock edge with valid and ready both high.
// ============================================================================
`timescale 1ns / 1ps

interface isa_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/isa_div.sv
// ============================================================================
// isa_div: serial restoring divider
// One quotient bit per cycle; done pulses in the cycle after the last step.
// ============================================================================
`timescale 1ns / 1ps

module isa_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [isa_pkg::OFF_W-1:0]     dividend,
    input  logic [isa_pkg::SPAN_W-1:0]    divisor,
    output logic                          done,
    output logic [isa_pkg::OFF_W-1:0]     quotient,
    output logic [isa_pkg::SPAN_W-1:0]    remainder
);

    localparam int QW = isa_pkg::OFF_W;
    localparam int RW = isa_pkg::SPAN_W;
    localparam int CW = isa_pkg::DIV_CNT_W;

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [QW-1:0] q_reg;
    logic [RW-1:0] r_reg;
    logic [RW-1:0] d_reg;

    logic [RW:0]   shifted;
    logic          ge;
    logic [RW:0]   diff;

    always_comb
    begin
        shifted = {r_reg, q_reg[QW-1]};
        ge      = (shifted >= {1'b0, d_reg});
        diff    = shifted - {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[QW-2:0], ge};
            r_reg <= ge ? diff[RW-1:0] : shifted[RW-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

endmodule

FILE: rtl/isa_ctrl.sv
// ============================================================================
// isa_ctrl: item sequencer
// Steps each item through dispatch and, for a scatter, division, index lookup and table update.
// ============================================================================
`timescale 1ns / 1ps

module isa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  isa_pkg::isa_sts_t sts,
    output isa_pkg::isa_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_READ_WAIT,
        S_DIV1,
        S_DIV2,
        S_POS,
        S_IDX,
        S_CHECK,
        S_MUL,
        S_TARGET,
        S_ADD,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_FINISH;
                unique case (sts.func)
                    isa_pkg::FUNC_LOAD:
                    begin
                        if (sts.item_in_tbl)
                        begin
                            cmd.tbl_we = 1'b1;
                        end
                        else
                        begin
                            cmd.st_we   = 1'b1;
                            cmd.st_code = isa_pkg::ST_BEYOND;
                        end
                    end
                    isa_pkg::FUNC_LOAD_IDX:
                    begin
                        if (sts.item_in_idx)
                        begin
                            cmd.idx_we = 1'b1;
                        end
                        else
                        begin
                            cmd.st_we   = 1'b1;
                            cmd.st_code = isa_pkg::ST_BEYOND;
                        end
                    end
                    isa_pkg::FUNC_SCATTER:
                    begin
                        if (sts.scat_skip)
                        begin
                            cmd.st_we   = 1'b1;
                            cmd.st_code = isa_pkg::ST_IGNORED;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = S_DIV1;
                        end
                    end
                    isa_pkg::FUNC_READ:
                    begin
                        if (sts.item_in_tbl)
                        begin
                            cmd.tbl_re = 1'b1;
                            state_next = S_READ_WAIT;
                        end
                        else
                        begin
                            cmd.st_we   = 1'b1;
                            cmd.st_code = isa_pkg::ST_BEYOND;
                        end
                    end
                endcase
            end
            S_READ_WAIT:
            begin
                cmd.rd_capture = 1'b1;
                state_next     = S_FINISH;
            end
            S_DIV1:
            begin
                // group/remainder ready: second pass splits the remainder
                if (sts.div_done)
                begin
                    cmd.take_q1       = 1'b1;
                    cmd.div_start     = 1'b1;
                    cmd.div_sel_inner = 1'b1;
                    state_next        = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (sts.div_done)
                begin
                    cmd.take_q2 = 1'b1;
                    state_next  = S_POS;
                end
            end
            S_POS:
            begin
                if (sts.pos_beyond)
                begin
                    cmd.st_we   = 1'b1;
                    cmd.st_code = isa_pkg::ST_IGNORED;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.idx_re = 1'b1;
                    state_next = S_IDX;
                end
            end
            S_IDX:
            begin
                cmd.calc_dest = 1'b1;
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.dest_bad)
                begin
                    cmd.st_we   = 1'b1;
                    cmd.st_code = isa_pkg::ST_DROPPED;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.calc_sum = 1'b1;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.calc_prod = 1'b1;
                state_next    = S_TARGET;
            end
            S_TARGET:
            begin
                if (sts.tgt_beyond)
                begin
                    cmd.st_we   = 1'b1;
                    cmd.st_code = isa_pkg::ST_BEYOND;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.tbl_re       = 1'b1;
                    cmd.tbl_asel_tgt = 1'b1;
                    state_next       = S_ADD;
                end
            end
            S_ADD:
            begin
                cmd.tbl_we       = 1'b1;
                cmd.tbl_wsrc_sum = 1'b1;
                cmd.tbl_asel_tgt = 1'b1;
                state_next       = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/isa_dp.sv
// ============================================================================
// isa_dp: scatter-add datapath
// Config registers, tables, divider, address arithmetic and result register.
// ============================================================================
`timescale 1ns / 1ps

module isa_dp #(
    parameter int TABLE_DEPTH = 4096,
    parameter int INDEX_DEPTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  isa_pkg::isa_cmd_t cmd,
    output isa_pkg::isa_sts_t sts,
    input  isa_pkg::isa_in_t  in_payload,
    input  logic              cfg_valid,
    input  isa_pkg::isa_cfg_t cfg_payload,
    input  logic              out_ready,
    output logic              out_valid,
    output isa_pkg::isa_out_t out_payload
);

    localparam int DW    = isa_pkg::DATA_W;
    localparam int OW    = isa_pkg::OFF_W;
    localparam int NW    = isa_pkg::DIM_W;
    localparam int SPW   = isa_pkg::SPAN_W;
    localparam int M1W   = isa_pkg::MUL1_W;
    localparam int SMW   = isa_pkg::SUM_W;
    localparam int PW    = isa_pkg::PROD_W;
    localparam int TGW   = isa_pkg::TGT_W;
    localparam int LIMW  = OW + 1;
    localparam int DSW   = DW + 2;
    localparam int TA_W  = $clog2(TABLE_DEPTH);
    localparam int IA_W  = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;

    // configuration
    logic [isa_pkg::ICNT_W-1:0] index_count_reg;
    logic [NW-1:0]              dim_size_reg;
    logic [NW-1:0]              inner_size_reg;
    logic [isa_pkg::SRC_W-1:0]  source_count_reg;
    logic                       elem_type_reg;

    // current item
    isa_pkg::isa_func_t         func_reg;
    logic [OW-1:0]              addr_reg;
    logic [DW-1:0]              data_reg;

    // scatter arithmetic
    logic [OW-1:0]              group_reg;
    logic [OW-1:0]              pos_reg;
    logic [NW-1:0]              inner_reg;
    logic [NW-1:0]              dest_reg;
    logic                       dest_bad_reg;
    logic [M1W-1:0]             mul1_reg;
    logic [SMW-1:0]             sum_reg;
    logic [PW-1:0]              prod_reg;

    // result
    logic [DW-1:0]              rd_reg;
    isa_pkg::isa_status_t       status_reg;
    logic                       out_valid_reg;
    isa_pkg::isa_out_t          out_payload_reg;

    // tables
    logic [DW-1:0]              tbl_mem [TABLE_DEPTH];
    logic [DW-1:0]              idx_mem [INDEX_DEPTH];
    logic [DW-1:0]              tbl_rdata_reg;
    logic [DW-1:0]              idx_rdata_reg;

    logic [SPW-1:0]             span;
    logic [OW-1:0]              div_dividend;
    logic [SPW-1:0]             div_divisor;
    logic                       div_done;
    logic [OW-1:0]              div_quot;
    logic [SPW-1:0]             div_rem;
    logic [DSW-1:0]             dest_wide;
    logic                       dest_neg;
    logic [TGW-1:0]             tgt_sum;
    logic                       tgt_beyond;
    logic                       pos_beyond;
    logic [TA_W-1:0]            tbl_addr;
    logic [DW-1:0]              tbl_wdata;
    logic                       out_free;

    always_comb
    begin
        span         = SPW'(index_count_reg) * SPW'(inner_size_reg);
        div_dividend = cmd.div_sel_inner ? div_rem[OW-1:0] : addr_reg;
        div_divisor  = cmd.div_sel_inner ? SPW'(inner_size_reg) : span;

        // negative index wraps once by dim_size
        dest_wide = {{2{idx_rdata_reg[DW-1]}}, idx_rdata_reg}
                  + (idx_rdata_reg[DW-1] ? DSW'(dim_size_reg) : DSW'(0));
        dest_neg  = dest_wide[DSW-1];

        tgt_sum    = TGW'(prod_reg) + TGW'(inner_reg);
        tgt_beyond = (tgt_sum >= TGW'(TABLE_DEPTH));
        pos_beyond = ({1'b0, pos_reg} >= LIMW'(INDEX_DEPTH));

        tbl_addr  = cmd.tbl_asel_tgt ? tgt_sum[TA_W-1:0] : addr_reg[TA_W-1:0];
        tbl_wdata = cmd.tbl_wsrc_sum
                  ? isa_pkg::narrow(tbl_rdata_reg + data_reg, elem_type_reg)
                  : isa_pkg::narrow(data_reg, elem_type_reg);

        out_free = !out_valid_reg || out_ready;

        sts.func        = func_reg;
        sts.item_in_tbl = ({1'b0, addr_reg} < LIMW'(TABLE_DEPTH));
        sts.item_in_idx = ({1'b0, addr_reg} < LIMW'(INDEX_DEPTH));
        sts.scat_skip   = (index_count_reg == '0) || (dim_size_reg == '0)
                       || (inner_size_reg == '0) || (addr_reg >= source_count_reg);
        sts.div_done    = div_done;
        sts.pos_beyond  = pos_beyond;
        sts.dest_bad    = dest_bad_reg;
        sts.tgt_beyond  = tgt_beyond;
        sts.out_free    = out_free;
    end

    isa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_count_reg  <= '0;
            dim_size_reg     <= '0;
            inner_size_reg   <= '0;
            source_count_reg <= '0;
            elem_type_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_payload.index)
                isa_pkg::REG_INDEX_COUNT:
                    index_count_reg <= cfg_payload.value[isa_pkg::ICNT_W-1:0];
                isa_pkg::REG_DIM_SIZE:
                    dim_size_reg <= cfg_payload.value[NW-1:0];
                isa_pkg::REG_INNER_SIZE:
                    inner_size_reg <= cfg_payload.value[NW-1:0];
                isa_pkg::REG_SOURCE_COUNT:
                    source_count_reg <= cfg_payload.value[isa_pkg::SRC_W-1:0];
                isa_pkg::REG_ELEM_TYPE:
                    elem_type_reg <= cfg_payload.value[0];
                default:
                begin
                end
            endcase
        end
    end

    // item, arithmetic and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            func_reg   <= in_payload.func;
            addr_reg   <= in_payload.addr;
            data_reg   <= in_payload.data;
            rd_reg     <= '0;
            status_reg <= isa_pkg::ST_DONE;
        end
        if (cmd.st_we)
        begin
            status_reg <= cmd.st_code;
        end
        if (cmd.rd_capture)
        begin
            rd_reg <= isa_pkg::narrow(tbl_rdata_reg, elem_type_reg);
        end
        if (cmd.take_q1)
        begin
            group_reg <= div_quot;
        end
        if (cmd.take_q2)
        begin
            pos_reg   <= div_quot;
            inner_reg <= div_rem[NW-1:0];
        end
        if (cmd.calc_dest)
        begin
            dest_reg     <= dest_wide[NW-1:0];
            dest_bad_reg <= dest_neg || (dest_wide >= DSW'(dim_size_reg));
            mul1_reg     <= M1W'(group_reg) * M1W'(dim_size_reg);
        end
        if (cmd.calc_sum)
        begin
            sum_reg <= SMW'(mul1_reg) + SMW'(dest_reg);
        end
        if (cmd.calc_prod)
        begin
            prod_reg <= PW'(sum_reg) * PW'(inner_size_reg);
        end
        if (cmd.out_load)
        begin
            out_payload_reg.read_data <= rd_reg;
            out_payload_reg.status    <= status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result table
    always_ff @(posedge clk)
    begin
        if (cmd.tbl_we)
        begin
            tbl_mem[tbl_addr] <= tbl_wdata;
        end
        if (cmd.tbl_re)
        begin
            tbl_rdata_reg <= tbl_mem[tbl_addr];
        end
    end

    // index table
    always_ff @(posedge clk)
    begin
        if (cmd.idx_we)
        begin
            idx_mem[addr_reg[IA_W-1:0]] <= data_reg;
        end
        if (cmd.idx_re)
        begin
            idx_rdata_reg <= idx_mem[pos_reg[IA_W-1:0]];
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_payload = out_payload_reg;

    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("result register overwritten before transfer");

    a_tgt_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.tbl_we && cmd.tbl_asel_tgt) |-> !tgt_beyond)
        else $error("scatter write beyond table");

    a_pos_in_index: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.idx_re |-> !pos_beyond)
        else $error("index read beyond index store");

endmodule

FILE: rtl/index_scatter_add.sv
// ============================================================================
// index_scatter_add: scatter-add engine, top level
// Items are handled one at a time; a scatter makes two 20-step passes of the
// shared serial divider plus index and table reads.
// The result register lets the next item in while a result waits.
// Reset: rst_n (async) clears control and configuration; the tables are not cleared.
// ============================================================================
`timescale 1ns / 1ps

module index_scatter_add #(
    parameter int TABLE_DEPTH = 4096,
    parameter int INDEX_DEPTH = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    isa_chan_if.sink   in_ch,
    isa_chan_if.source out_ch,
    isa_chan_if.sink   cfg_ch
);

    isa_pkg::isa_cmd_t cmd;
    isa_pkg::isa_sts_t sts;

    // configuration writes are taken in any cycle
    assign cfg_ch.ready = 1'b1;

    isa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    isa_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .INDEX_DEPTH (INDEX_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_payload  (in_ch.payload),
        .cfg_valid   (cfg_ch.valid),
        .cfg_payload (cfg_ch.payload),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .out_payload (out_ch.payload)
    );

endmodule

FILE: dv/tb.sv
// ============================================================================
// tb: testbench of the index_scatter_add engine
// Drives loads, index loads, scatter-adds and reads over valid/ready channels
// across several shapes and both element types. A scoreboard predicts every
// result from its own copy of the tables and registers and checks each
// returned transfer field by field, in order.
// ============================================================================
`timescale 1ns / 1ps

module tb;

    localparam int     TABLE_DEPTH   = 4096;
    localparam int     INDEX_DEPTH   = 256;
    localparam int     SETTLE_CYCLES = 80;          // well past the longest item
    localparam longint LIMIT_NS      = 10_000_000;
    localparam int     RECENT_MAX    = 64;
    localparam int     DW            = isa_pkg::DATA_W;
    localparam int     OW            = isa_pkg::OFF_W;
    localparam logic [isa_pkg::REG_IDX_W-1:0] REG_SPARE = 3'd7;   // no register behind it

    class scatter_tracker;
        logic [DW-1:0]     tbl_mem [TABLE_DEPTH];
        bit                tbl_set [TABLE_DEPTH];
        logic [DW-1:0]     idx_mem [INDEX_DEPTH];
        bit                idx_set [INDEX_DEPTH];
        int unsigned       index_count;
        int unsigned       dim_size;
        int unsigned       inner_size;
        int unsigned       source_count;
        bit                int8_mode;
        isa_pkg::isa_out_t awaited [$];
        int unsigned       recent_tbl [$];
        int                errors;

        function new();
            index_count  = 0;
            dim_size     = 0;
            inner_size   = 0;
            source_count = 0;
            int8_mode    = 0;
            errors       = 0;
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        function void set_reg(logic [isa_pkg::REG_IDX_W-1:0] idx, logic [DW-1:0] v);
            unique case (idx)
                isa_pkg::REG_INDEX_COUNT:  index_count  = 32'(v[isa_pkg::ICNT_W-1:0]);
                isa_pkg::REG_DIM_SIZE:     dim_size     = 32'(v[isa_pkg::DIM_W-1:0]);
                isa_pkg::REG_INNER_SIZE:   inner_size   = 32'(v[isa_pkg::DIM_W-1:0]);
                isa_pkg::REG_SOURCE_COUNT: source_count = 32'(v[isa_pkg::SRC_W-1:0]);
                isa_pkg::REG_ELEM_TYPE:    int8_mode    = v[0];
                default: ;
            endcase
        endfunction

        function logic [DW-1:0] shrink(logic [DW-1:0] v);
            return int8_mode ? {{(DW-8){v[7]}}, v[7:0]} : v;
        endfunction

        function void write_tbl(int unsigned a, logic [DW-1:0] v);
            tbl_mem[a] = v;
            tbl_set[a] = 1'b1;
            recent_tbl.push_back(a);
            if (recent_tbl.size() > RECENT_MAX)
                void'(recent_tbl.pop_front());
        endfunction

        // Expected result of one item; commit updates the tables.
        // miss_* report an entry that the item would read before any write.
        function isa_pkg::isa_out_t predict(isa_pkg::isa_in_t it, bit commit,
                                            output int miss_tbl, output int miss_idx);
            isa_pkg::isa_out_t r;
            longint unsigned   span, grp, rem, pos, inr, tgt;
            longint            dest, dim_l;
            logic [DW-1:0]     raw;
            r.read_data = '0;
            r.status    = isa_pkg::ST_DONE;
            miss_tbl    = -1;
            miss_idx    = -1;
            dim_l       = dim_size;
            unique case (it.func)
                isa_pkg::FUNC_LOAD:
                    if (it.addr < TABLE_DEPTH)
                    begin
                        if (commit)
                            write_tbl(32'(it.addr), shrink(it.data));
                    end
                    else
                        r.status = isa_pkg::ST_BEYOND;
                isa_pkg::FUNC_LOAD_IDX:
                    if (it.addr < INDEX_DEPTH)
                    begin
                        if (commit)
                        begin
                            idx_mem[it.addr] = it.data;
                            idx_set[it.addr] = 1'b1;
                        end
                    end
                    else
                        r.status = isa_pkg::ST_BEYOND;
                isa_pkg::FUNC_SCATTER:
                    if (index_count == 0 || dim_size == 0 || inner_size == 0 ||
                        it.addr >= source_count)
                        r.status = isa_pkg::ST_IGNORED;
                    else
                    begin
                        span = longint'(index_count) * inner_size;
                        grp  = it.addr / span;
                        rem  = it.addr % span;
                        pos  = rem / inner_size;
                        inr  = rem % inner_size;
                        if (pos >= INDEX_DEPTH)
                            r.status = isa_pkg::ST_IGNORED;
                        else if (!idx_set[pos])
                            miss_idx = int'(pos);
                        else
                        begin
                            raw  = idx_mem[pos];
                            dest = $signed(raw);
                            // negative index wraps once by the dimension
                            if (dest < 0)
                                dest = dest + dim_l;
                            if (dest < 0 || dest >= dim_l)
                                r.status = isa_pkg::ST_DROPPED;
                            else
                            begin
                                tgt = (grp * dim_size + longint'(dest)) * inner_size + inr;
                                if (tgt >= TABLE_DEPTH)
                                    r.status = isa_pkg::ST_BEYOND;
                                else if (!tbl_set[tgt])
                                    miss_tbl = int'(tgt);
                                else if (commit)
                                    write_tbl(32'(tgt), shrink(tbl_mem[tgt] + it.data));
                            end
                        end
                    end
                default:
                    if (it.addr < TABLE_DEPTH)
                    begin
                        if (!tbl_set[it.addr])
                            miss_tbl = int'(it.addr);
                        else
                            r.read_data = shrink(tbl_mem[it.addr]);
                    end
                    else
                        r.status = isa_pkg::ST_BEYOND;
            endcase
            return r;
        endfunction

        task note_item(isa_pkg::isa_in_t it);
            isa_pkg::isa_out_t r;
            int                mt, mi;
            r = predict(it, 1'b1, mt, mi);
            if (mt >= 0 || mi >= 0)
                report($sformatf("item reads an unwritten entry, addr %0h", it.addr));
            awaited.push_back(r);
        endtask

        task check_result(isa_pkg::isa_out_t got);
            isa_pkg::isa_out_t want;
            if (awaited.size() == 0)
            begin
                report("result transfer with nothing awaited");
                return;
            end
            want = awaited.pop_front();
            if (got.read_data !== want.read_data)
                report($sformatf("read_data %0h, expected %0h",
                                 got.read_data, want.read_data));
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
        endtask
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    isa_chan_if #(.T(isa_pkg::isa_in_t))  in_ch ();
    isa_chan_if #(.T(isa_pkg::isa_out_t)) out_ch ();
    isa_chan_if #(.T(isa_pkg::isa_cfg_t)) cfg_ch ();

    index_scatter_add #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .INDEX_DEPTH(INDEX_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    scatter_tracker trk;

    // Result side: check each transfer, then pick the next ready value from
    // stretches of free flow, random, mostly stalled and fully stalled.
    int stall_left = 0;
    int stall_mode = 0;

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            trk.check_result(out_ch.payload);
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = (stall_mode == 3) ? $urandom_range(1, 12) : $urandom_range(4, 60);
        end
        stall_left--;
        unique case (stall_mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
            2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
            default: out_ch.ready <= 1'b0;
        endcase
    end

    initial
    begin
        #(LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    task automatic wait_idle(bit settle);
        while (trk.awaited.size() != 0)
            @(posedge clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves valid high; the caller lowers it or sends the next item.
    task automatic drive_item(isa_pkg::isa_in_t it);
        in_ch.payload <= it;
        in_ch.valid   <= 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        trk.note_item(it);
    endtask

    task automatic push_item(isa_pkg::isa_func_t f, logic [OW-1:0] a, logic [DW-1:0] d);
        isa_pkg::isa_in_t it;
        it.func = f;
        it.addr = a;
        it.data = d;
        drive_item(it);
    endtask

    // Bits above the register width are filled with noise half the time.
    task automatic write_reg(logic [isa_pkg::REG_IDX_W-1:0] idx, logic [DW-1:0] v, int w);
        logic [DW-1:0] junk;
        junk = $urandom;
        if (w < DW && $urandom_range(0, 1))
            v = v | (junk << w);
        cfg_ch.payload <= {idx, v};
        cfg_ch.valid   <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        trk.set_reg(idx, v);
    endtask

    task automatic set_shape(int unsigned ic, int unsigned dm, int unsigned inr,
                             int unsigned src, bit e8);
        wait_idle(1'b1);
        write_reg(isa_pkg::REG_INDEX_COUNT, ic, isa_pkg::ICNT_W);
        write_reg(isa_pkg::REG_DIM_SIZE, dm, isa_pkg::DIM_W);
        write_reg(isa_pkg::REG_INNER_SIZE, inr, isa_pkg::DIM_W);
        write_reg(isa_pkg::REG_SOURCE_COUNT, src, isa_pkg::SRC_W);
        write_reg(isa_pkg::REG_ELEM_TYPE, 32'(e8), 1);
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_SPARE, $urandom, DW);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [DW-1:0] pick_data();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return $urandom;
        if (r < 75)
            return $urandom_range(0, 511) - 256;
        unique case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h0000_007F;
            default: return 32'h0000_0080;
        endcase
    endfunction

    // Mostly inside or just around [-dim, dim) so most scatters land.
    function automatic logic [DW-1:0] pick_index_value();
        int unsigned r, dm;
        r  = $urandom_range(0, 99);
        dm = trk.dim_size;
        if (r < 75)
            return $urandom_range(0, 2 * dm + 3) - (dm + 2);
        if (r < 85)
            unique case ($urandom_range(0, 2))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                default: return 32'hFFFF_FFFF;
            endcase
        return $urandom;
    endfunction

    function automatic logic [OW-1:0] pick_tbl_addr();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60 && trk.recent_tbl.size() > 0)
            return OW'(trk.recent_tbl[$urandom_range(0, trk.recent_tbl.size() - 1)]);
        if (r < 90)
            return OW'($urandom_range(0, TABLE_DEPTH - 1));
        return OW'($urandom_range(TABLE_DEPTH, 20'hFFFFF));
    endfunction

    function automatic logic [OW-1:0] pick_idx_addr();
        int unsigned r, lim;
        r   = $urandom_range(0, 99);
        lim = (trk.index_count == 0 || trk.index_count > INDEX_DEPTH) ?
              INDEX_DEPTH : trk.index_count;
        if (r < 80)
            return OW'($urandom_range(0, lim - 1));
        if (r < 90)
            return OW'($urandom_range(INDEX_DEPTH, 20'hFFFFF));
        return OW'($urandom);
    endfunction

    // Well-formed offsets are built from group, position and inner offset.
    function automatic logic [OW-1:0] pick_offset();
        int unsigned     r, ic, inr, src, pos, inner, grp;
        longint unsigned off;
        r   = $urandom_range(0, 99);
        ic  = trk.index_count;
        inr = trk.inner_size;
        src = trk.source_count;
        if (ic == 0 || inr == 0 || src == 0 || r >= 90)
            return OW'($urandom);
        if (r >= 78)
            return (src <= 20'hFFFFF) ? OW'($urandom_range(src, 20'hFFFFF)) : OW'($urandom);
        pos   = $urandom_range(0, ic - 1);
        inner = $urandom_range(0, inr - 1);
        grp   = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(0, 7);
        off   = (longint'(grp) * ic + pos) * inr + inner;
        if (off >= src)
            off = $urandom_range(0, src - 1);
        return off[OW-1:0];
    endfunction

    // An item that would read an unwritten entry becomes a load of that entry.
    task automatic make_item(output isa_pkg::isa_in_t it);
        int unsigned       r;
        int                miss_tbl, miss_idx;
        isa_pkg::isa_out_t unused;
        r       = $urandom_range(0, 99);
        it.data = pick_data();
        if (r < 12)
        begin
            it.func = isa_pkg::FUNC_LOAD;
            it.addr = pick_tbl_addr();
        end
        else if (r < 22)
        begin
            it.func = isa_pkg::FUNC_LOAD_IDX;
            it.addr = pick_idx_addr();
            it.data = pick_index_value();
        end
        else if (r < 75)
        begin
            it.func = isa_pkg::FUNC_SCATTER;
            it.addr = pick_offset();
        end
        else
        begin
            it.func = isa_pkg::FUNC_READ;
            it.addr = pick_tbl_addr();
        end
        unused = trk.predict(it, 1'b0, miss_tbl, miss_idx);
        if (miss_idx >= 0)
        begin
            it.func = isa_pkg::FUNC_LOAD_IDX;
            it.addr = OW'(miss_idx);
            it.data = pick_index_value();
        end
        else if (miss_tbl >= 0)
        begin
            it.func = isa_pkg::FUNC_LOAD;
            it.addr = OW'(miss_tbl);
        end
    endtask

    task automatic run_phase(int unsigned ic, int unsigned dm, int unsigned inr,
                             int unsigned src, bit e8, int n, bit hold_mid);
        isa_pkg::isa_in_t it;
        int               burst;
        set_shape(ic, dm, inr, src, e8);
        burst = $urandom_range(1, 24);
        for (int k = 0; k < n; k++)
        begin
            make_item(it);
            drive_item(it);
            burst--;
            if (k == n - 1)
                in_ch.valid <= 1'b0;
            else if (hold_mid && k == n / 2)
            begin
                // hold off until the engine has returned everything
                in_ch.valid <= 1'b0;
                wait_idle(1'b0);
            end
            else if (burst <= 0)
            begin
                burst = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0)
                begin
                    in_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 10)) @(posedge clk);
                end
            end
        end
    endtask

    initial
    begin
        trk            = new();
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.payload = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers still at reset: degenerate shape
        push_item(isa_pkg::FUNC_SCATTER, 20'd0, 32'd7);
        in_ch.valid <= 1'b0;

        set_shape(4, 8, 4, 128, 1'b0);
        push_item(isa_pkg::FUNC_LOAD, 20'd0, 32'h8000_0000);
        push_item(isa_pkg::FUNC_LOAD, 20'd4095, 32'h7FFF_FFFF);
        push_item(isa_pkg::FUNC_LOAD, 20'd4096, 32'd1);
        push_item(isa_pkg::FUNC_LOAD, 20'hFFFFF, 32'hFFFF_FFFF);
        push_item(isa_pkg::FUNC_LOAD_IDX, 20'd0, 32'd3);
        push_item(isa_pkg::FUNC_LOAD_IDX, 20'd1, 32'hFFFF_FFFF);  // wraps to 7
        push_item(isa_pkg::FUNC_LOAD_IDX, 20'd2, 32'd8);          // at dim_size
        push_item(isa_pkg::FUNC_LOAD_IDX, 20'd3, -32'sd9);        // negative after wrap
        push_item(isa_pkg::FUNC_LOAD_IDX, 20'd255, 32'h8000_0000);
        push_item(isa_pkg::FUNC_LOAD_IDX, 20'd256, 32'd5);
        push_item(isa_pkg::FUNC_LOAD_IDX, 20'hFFFFF, 32'hFFFF_FFFF);
        push_item(isa_pkg::FUNC_LOAD, 20'd12, 32'h7FFF_FFFF);
        push_item(isa_pkg::FUNC_SCATTER, 20'd0, 32'd1);           // wraps past max int
        push_item(isa_pkg::FUNC_LOAD, 20'd28, -32'sd5);
        push_item(isa_pkg::FUNC_SCATTER, 20'd4, 32'd5);
        push_item(isa_pkg::FUNC_SCATTER, 20'd8, 32'd1);
        push_item(isa_pkg::FUNC_SCATTER, 20'd12, 32'd1);
        push_item(isa_pkg::FUNC_SCATTER, 20'd128, 32'd1);         // offset past source
        push_item(isa_pkg::FUNC_READ, 20'd12, 32'hFFFF_FFFF);
        push_item(isa_pkg::FUNC_READ, 20'd28, 32'd0);
        push_item(isa_pkg::FUNC_READ, 20'd0, 32'd0);
        push_item(isa_pkg::FUNC_READ, 20'hFFFFF, 32'd0);
        in_ch.valid <= 1'b0;

        // int8 storage, and a target past the table end
        set_shape(1, 1, 1, 5000, 1'b1);
        push_item(isa_pkg::FUNC_LOAD_IDX, 20'd0, 32'd0);
        push_item(isa_pkg::FUNC_LOAD, 20'd0, 32'h0000_017F);
        push_item(isa_pkg::FUNC_SCATTER, 20'd0, 32'd1);
        push_item(isa_pkg::FUNC_READ, 20'd0, 32'd0);
        push_item(isa_pkg::FUNC_READ, 20'd4095, 32'd0);
        push_item(isa_pkg::FUNC_SCATTER, 20'd4096, 32'd1);
        in_ch.valid <= 1'b0;

        run_phase(4, 8, 4, 512, 1'b0, 160, 1'b0);
        run_phase(3, 5, 1, 60, 1'b1, 130, 1'b1);
        run_phase(16, 16, 16, 20'hFFFFF, 1'b0, 140, 1'b0);
        run_phase(256, 4096, 1, 4096, 1'b0, 130, 1'b0);
        run_phase(511, 10, 1, 100000, 1'b1, 130, 1'b0);
        run_phase(2, 8191, 8191, 20'hFFFFF, 1'b0, 110, 1'b0);
        run_phase(0, 0, 0, 0, 1'b0, 30, 1'b0);
        run_phase(7, 0, 3, 300, 1'b1, 25, 1'b0);
        run_phase(7, 3, 0, 300, 1'b0, 25, 1'b0);

        wait_idle(1'b1);
        if (trk.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
